// ----- rtl/core/sbpp_pkg.sv -----
// Shared types and constants for the six-button pad poller.
package sbpp_pkg;

  // Channel widths
  localparam int PIN_W      = 6;
  localparam int BTN_W      = 8;
  localparam int AXES_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_PERIOD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_INTERVAL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_UNIT     = 2'd3;

  // Register reset values
  localparam logic [15:0] HALF_PERIOD_RST   = 16'd100;
  localparam logic [15:0] SCAN_PERIOD_RST   = 16'd16384;
  localparam logic [7:0]  IDLE_INTERVAL_RST = 8'(500 / 4);
  localparam logic [7:0]  IDLE_UNIT_RST     = 8'd4;

  // Report constants
  localparam logic [AXES_W-1:0] AXES_CENTRE = 4'h5;
  localparam logic [15:0]       IDLE_CAP    = 16'h7FFF;
  localparam logic [15:0]       TIMER_MAX   = 16'hFFFF;

  // Select line phases: odd phases drive select low
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LOW1,
    PH_HIGH1,
    PH_LOW2,
    PH_HIGH2,
    PH_LOW3,
    PH_HIGH3,
    PH_LOW4
  } phase_t;

  // Sampling and publish strobes from the sequencer to the pad lanes
  typedef struct packed {
    logic sample_high;
    logic sample_low;
    logic sample_extra;
    logic publish;
  } scan_strobe_t;

endpackage

// ----- rtl/core/sbpp_in_if.sv -----
// Tick channel carrying the raw pin lines of both pads.
interface sbpp_in_if;
  import sbpp_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIN_W-1:0] pad_one_lines;
  logic [PIN_W-1:0] pad_two_lines;

  modport source (output valid, output pad_one_lines, output pad_two_lines, input ready);
  modport sink   (input valid, input pad_one_lines, input pad_two_lines, output ready);
endinterface

// ----- rtl/core/sbpp_out_if.sv -----
// Result channel carrying select level, published reports and send flag.
interface sbpp_out_if;
  import sbpp_pkg::*;

  logic              valid;
  logic              ready;
  logic              select_level;
  logic              report_update;
  logic [BTN_W-1:0]  buttons_one;
  logic [AXES_W-1:0] axes_one;
  logic [BTN_W-1:0]  buttons_two;
  logic [AXES_W-1:0] axes_two;
  logic              send_report;

  modport source (output valid, output select_level, output report_update,
                  output buttons_one, output axes_one, output buttons_two,
                  output axes_two, output send_report, input ready);
  modport sink   (input valid, input select_level, input report_update,
                  input buttons_one, input axes_one, input buttons_two,
                  input axes_two, input send_report, output ready);
endinterface

// ----- rtl/core/sbpp_cfg_if.sv -----
// Configuration write channel: register index and write data.
interface sbpp_cfg_if;
  import sbpp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/six_button_pad_poller.sv -----
// Top level of the six-button pad poller: config registers, sequencer, lanes, send merge, output register.
//
// Takes one time tick per clock, carrying the active-low pin lines of two
// six-button pads, and returns one result per tick: the select level to
// drive next, the publish flag, both pads' published button and axis
// reports, and the send flag. Every tick is fully processed in the cycle it
// is accepted by the select sequencer, two pad lanes and the send merge
// stage; its result appears in the output register on the next cycle. A new
// tick is accepted every cycle as long as the output register is empty or
// being drained, so the sustained rate is one tick per clock. Configuration
// writes are accepted every cycle and take effect on the next tick.
module six_button_pad_poller (
  input  logic              clk,
  input  logic              rst,
  sbpp_in_if.sink           pads,
  sbpp_out_if.source        report,
  sbpp_cfg_if.sink          cfg
);
  import sbpp_pkg::*;

  logic [15:0]       half_period;
  logic [15:0]       scan_period;
  logic [7:0]        idle_interval;
  logic [7:0]        idle_unit;
  logic              step;
  scan_strobe_t      strobe;
  logic              select_next;
  logic [BTN_W-1:0]  buttons_next [2];
  logic [AXES_W-1:0] axes_next [2];
  logic [1:0]        lane_changed;
  logic              send_next;
  logic              out_valid;

  // Configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period   <= HALF_PERIOD_RST;
      scan_period   <= SCAN_PERIOD_RST;
      idle_interval <= IDLE_INTERVAL_RST;
      idle_unit     <= IDLE_UNIT_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_HALF_PERIOD:   half_period   <= cfg.data;
        CFG_SCAN_PERIOD:   scan_period   <= cfg.data;
        CFG_IDLE_INTERVAL: idle_interval <= cfg.data[7:0];
        CFG_IDLE_UNIT:     idle_unit     <= cfg.data[7:0];
      endcase
    end
  end

  // Accept a tick whenever the output register can take its result
  assign pads.ready = !out_valid || report.ready;
  assign step       = pads.valid && pads.ready;

  sbpp_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .half_period (half_period),
    .scan_period (scan_period),
    .strobe      (strobe),
    .select_next (select_next)
  );

  sbpp_lane u_lane_one (
    .clk                (clk),
    .rst                (rst),
    .step               (step),
    .lines              (pads.pad_one_lines),
    .strobe             (strobe),
    .shown_buttons_next (buttons_next[0]),
    .shown_axes_next    (axes_next[0]),
    .changed            (lane_changed[0])
  );

  sbpp_lane u_lane_two (
    .clk                (clk),
    .rst                (rst),
    .step               (step),
    .lines              (pads.pad_two_lines),
    .strobe             (strobe),
    .shown_buttons_next (buttons_next[1]),
    .shown_axes_next    (axes_next[1]),
    .changed            (lane_changed[1])
  );

  sbpp_send u_send (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .lane_changed  (lane_changed),
    .idle_interval (idle_interval),
    .idle_unit     (idle_unit),
    .send          (send_next)
  );

  // Output register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      report.select_level  <= select_next;
      report.report_update <= strobe.publish;
      report.buttons_one   <= buttons_next[0];
      report.axes_one      <= axes_next[0];
      report.buttons_two   <= buttons_next[1];
      report.axes_two      <= axes_next[1];
      report.send_report   <= send_next;
    end
  end

  assign report.valid = out_valid;
endmodule

// ----- rtl/core/sbpp_seq.sv -----
// Select line sequencer: scan timer, half phase timer and phase state.
module sbpp_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [15:0]           half_period,
  input  logic [15:0]           scan_period,
  output sbpp_pkg::scan_strobe_t strobe,
  output logic                  select_next
);
  import sbpp_pkg::*;

  phase_t      phase;
  phase_t      phase_next;
  logic [15:0] half_timer;
  logic [15:0] half_timer_next;
  logic [15:0] scan_timer;
  logic [15:0] scan_timer_next;
  logic [16:0] half_inc;
  logic [15:0] scan_inc;
  logic        half_done;
  logic        scan_due;

  // Timer increments and phase end / scan start conditions
  assign half_inc  = {1'b0, half_timer} + 17'd1;
  assign half_done = (half_inc >= {1'b0, half_period});
  assign scan_inc  = (scan_timer == TIMER_MAX) ? TIMER_MAX : scan_timer + 16'd1;
  assign scan_due  = (phase == PH_IDLE) && (scan_inc >= scan_period);

  // Next phase
  always_comb begin
    phase_next = phase;
    if (step) begin
      if (phase != PH_IDLE && half_done) begin
        unique case (phase)
          PH_LOW1:  phase_next = PH_HIGH1;
          PH_HIGH1: phase_next = PH_LOW2;
          PH_LOW2:  phase_next = PH_HIGH2;
          PH_HIGH2: phase_next = PH_LOW3;
          PH_LOW3:  phase_next = PH_HIGH3;
          PH_HIGH3: phase_next = PH_LOW4;
          PH_LOW4:  phase_next = PH_IDLE;
          PH_IDLE:  phase_next = PH_IDLE;
        endcase
      end
      if (scan_due) begin
        phase_next = PH_LOW1;
      end
    end
  end

  // Next timer values
  always_comb begin
    half_timer_next = half_timer;
    scan_timer_next = scan_timer;
    if (step) begin
      if (phase != PH_IDLE) begin
        half_timer_next = half_done ? 16'd0 : half_inc[15:0];
      end
      if (scan_due) begin
        half_timer_next = 16'd0;
        scan_timer_next = 16'd0;
      end else begin
        scan_timer_next = scan_inc;
      end
    end
  end

  // Strobes for the lanes and the select level after this tick
  always_comb begin
    strobe = '0;
    if (step) begin
      strobe.sample_high = scan_due;
      if (phase != PH_IDLE && half_done) begin
        unique case (phase)
          PH_LOW1:  strobe.sample_low   = 1'b1;
          PH_HIGH3: strobe.sample_extra = 1'b1;
          PH_LOW4:  strobe.publish      = 1'b1;
          default:  strobe = strobe;
        endcase
      end
    end
    select_next = ~phase_next[0];
  end

  // Hold state between ticks
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      half_timer <= 16'd0;
      scan_timer <= 16'd0;
    end else begin
      phase      <= phase_next;
      half_timer <= half_timer_next;
      scan_timer <= scan_timer_next;
    end
  end
endmodule

// ----- rtl/core/sbpp_lane.sv -----
// One pad lane: samples its pins, keeps working and shown reports.
module sbpp_lane (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [sbpp_pkg::PIN_W-1:0]   lines,
  input  sbpp_pkg::scan_strobe_t       strobe,
  output logic [sbpp_pkg::BTN_W-1:0]   shown_buttons_next,
  output logic [sbpp_pkg::AXES_W-1:0]  shown_axes_next,
  output logic                         changed
);
  import sbpp_pkg::*;

  logic [BTN_W-1:0]  work_buttons;
  logic [BTN_W-1:0]  work_buttons_next;
  logic [AXES_W-1:0] work_axes;
  logic [AXES_W-1:0] work_axes_next;
  logic [BTN_W-1:0]  shown_buttons;
  logic [AXES_W-1:0] shown_axes;
  logic [PIN_W-1:0]  low;

  assign low = ~lines;

  // Sample pins into the working report
  always_comb begin
    logic [AXES_W-1:0] ax;
    ax = AXES_CENTRE;
    if (low[0]) ax = ax - 4'd4;
    if (low[1]) ax = ax + 4'd4;
    if (low[2]) ax = ax - 4'd1;
    if (low[3]) ax = ax + 4'd1;
    work_buttons_next = work_buttons;
    work_axes_next    = work_axes;
    if (strobe.sample_high) begin
      // B and C from pins 6 and 9, directions from pins 1 to 4
      work_buttons_next = {5'b0, low[5], low[4], 1'b0};
      work_axes_next    = ax;
    end else if (strobe.sample_low) begin
      // A and Start
      work_buttons_next = work_buttons | {low[5], 6'b0, low[4]};
    end else if (strobe.sample_extra) begin
      // Mode, Z, Y, X on the direction pins
      work_buttons_next = work_buttons | {1'b0, low[3], low[0], low[1], low[2], 3'b0};
    end
  end

  // Publish and detect a change against the previous shown report
  assign shown_buttons_next = strobe.publish ? work_buttons : shown_buttons;
  assign shown_axes_next    = strobe.publish ? work_axes : shown_axes;
  assign changed = strobe.publish &&
                   ((work_buttons != shown_buttons) || (work_axes != shown_axes));

  always_ff @(posedge clk) begin
    if (rst) begin
      work_buttons  <= '0;
      work_axes     <= AXES_CENTRE;
      shown_buttons <= '0;
      shown_axes    <= AXES_CENTRE;
    end else if (step) begin
      work_buttons  <= work_buttons_next;
      work_axes     <= work_axes_next;
      shown_buttons <= shown_buttons_next;
      shown_axes    <= shown_axes_next;
    end
  end
endmodule

// ----- rtl/core/sbpp_send.sv -----
// Merge stage: combines lane change flags with the idle timer into a send.
module sbpp_send (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [1:0] lane_changed,
  input  logic [7:0] idle_interval,
  input  logic [7:0] idle_unit,
  output logic       send
);
  import sbpp_pkg::*;

  logic [15:0] idle_timer;
  logic [15:0] idle_limit;
  logic        expired;

  // Idle limit and expiry
  assign idle_limit = {8'b0, idle_interval} * {8'b0, idle_unit};
  assign expired    = (idle_interval != 8'd0) &&
                      ((idle_timer > idle_limit) || (idle_timer > IDLE_CAP));
  assign send       = (|lane_changed) || expired;

  // Clear on send, else count up and saturate
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timer <= 16'd0;
    end else if (step) begin
      if (send) begin
        idle_timer <= 16'd0;
      end else if (idle_timer != TIMER_MAX) begin
        idle_timer <= idle_timer + 16'd1;
      end
    end
  end
endmodule

// ----- rtl/core/sbpp_checker.sv -----
// Port-level assertions for the six-button pad poller and their bind.
module sbpp_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic select_level,
  input logic report_update
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Drop the output register on reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // Accept ticks while the output register is empty
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // Publish only when select has returned high
  a_publish_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && report_update |-> select_level)
    else $error("report published with select low");

  // Every accepted tick yields a result on the next cycle
  a_tick_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted tick gave no result");

endmodule

bind six_button_pad_poller sbpp_checker u_sbpp_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (pads.valid),
  .in_ready      (pads.ready),
  .out_valid     (report.valid),
  .out_ready     (report.ready),
  .select_level  (report.select_level),
  .report_update (report.report_update)
);
